// ----- hw/rtl/tcpq_pkg.sv -----
// -----------------------------------------------------------------------------
// tcpq_pkg: shared types and codes
// Entry, command, result and history record layouts for the two-class queue.
// -----------------------------------------------------------------------------
package tcpq_pkg;

  localparam logic [2:0] MODE_REGISTER = 3'd0;
  localparam logic [2:0] MODE_SERVE    = 3'd1;
  localparam logic [2:0] MODE_BOOST    = 3'd2;
  localparam logic [2:0] MODE_WITHDRAW = 3'd3;
  localparam logic [2:0] MODE_UNDO     = 3'd4;
  localparam logic [2:0] MODE_STATUS   = 3'd5;

  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_EMPTY      = 3'd1;
  localparam logic [2:0] ST_IGNORED    = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_HIST_EMPTY = 3'd4;

  localparam logic [1:0] ACT_REGISTER = 2'd0;
  localparam logic [1:0] ACT_SERVE    = 2'd1;
  localparam logic [1:0] ACT_BOOST    = 2'd2;
  localparam logic [1:0] ACT_WITHDRAW = 2'd3;

  typedef struct packed {
    logic        [15:0] id;
    logic signed [15:0] level;
    logic        [15:0] arrival;
  } entry_t;

  typedef struct packed {
    logic        [2:0]  mode;
    logic        [15:0] entry_id;
    logic signed [15:0] level;
    logic               is_priority;
    logic signed [15:0] boost_amount;
  } in_item_t;

  typedef struct packed {
    logic        [2:0]  status_code;
    logic        [15:0] served_id;
    logic signed [15:0] served_level;
    logic               served_was_priority;
    logic        [4:0]  priority_count;
    logic        [4:0]  fifo_count;
  } out_item_t;

  typedef struct packed {
    entry_t             e;
    logic               prio;
    logic        [1:0]  code;
    logic signed [15:0] amount;
  } hist_rec_t;

  // broadcast to every cell of a row
  typedef struct packed {
    logic        do_ins;
    logic        do_rem;
    logic        head_sel;
    logic        fifo_mode;
    logic [15:0] key;
    entry_t      ins_entry;
  } row_op_t;

  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic signed [15:0] b,
                                                 input logic sub);
    logic signed [16:0] s;
    s = sub ? (17'(a) - 17'(b)) : (17'(a) + 17'(b));
    if (s > 17'sd32767) return 16'sh7fff;
    else if (s < -17'sd32768) return 16'sh8000;
    else return s[15:0];
  endfunction

endpackage

// ----- hw/rtl/tcpq_cell.sv -----
// -----------------------------------------------------------------------------
// tcpq_cell: one queue slot
// Holds an entry; on insert takes the new item or the left neighbour's entry,
// on removal takes the right neighbour's entry.
// -----------------------------------------------------------------------------
module tcpq_cell #(
  parameter bit IS_HEAD = 1'b0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  tcpq_pkg::row_op_t op,
  input  logic             stay_in,
  input  logic             hit_in,
  input  tcpq_pkg::entry_t left_entry,
  input  logic             left_valid,
  input  tcpq_pkg::entry_t right_entry,
  input  logic             right_valid,
  output tcpq_pkg::entry_t entry,
  output logic             valid,
  output logic             stay_out,
  output logic             hit_out,
  output logic             first_hit
);

  tcpq_pkg::entry_t entry_r;
  logic             valid_r;
  logic             beats;
  logic             match;

  // new item goes ahead of this slot
  assign beats = (op.ins_entry.level > entry_r.level) ||
                 ((op.ins_entry.level == entry_r.level) &&
                  (op.ins_entry.arrival < entry_r.arrival));
  assign stay_out  = valid_r & (op.fifo_mode | ~beats);
  assign match     = valid_r & (op.head_sel ? IS_HEAD : (entry_r.id == op.key));
  assign hit_out   = hit_in | match;
  assign first_hit = match & ~hit_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (op.do_ins && !stay_out) begin
      valid_r <= stay_in ? 1'b1 : left_valid;
    end else if (op.do_rem && hit_out) begin
      valid_r <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op.do_ins && !stay_out) begin
      entry_r <= stay_in ? op.ins_entry : left_entry;
    end else if (op.do_rem && hit_out) begin
      entry_r <= right_entry;
    end
  end

  assign entry = entry_r;
  assign valid = valid_r;

endmodule

// ----- hw/rtl/tcpq_row.sv -----
// -----------------------------------------------------------------------------
// tcpq_row: chain of queue cells
// Slot 0 is the head. Sorted or FIFO insert, first-match removal and lookup.
// -----------------------------------------------------------------------------
module tcpq_row #(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tcpq_pkg::row_op_t op,
  output logic              found,
  output tcpq_pkg::entry_t  found_entry,
  output tcpq_pkg::entry_t  head_entry
);

  tcpq_pkg::entry_t ent   [DEPTH];
  logic             vld   [DEPTH];
  logic             stay  [DEPTH+1];
  logic             hit   [DEPTH+1];
  logic             first [DEPTH];

  assign stay[0] = 1'b1;
  assign hit[0]  = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tcpq_pkg::entry_t le, re;
    logic             lv, rv;
    if (i == 0) begin : g_l0
      assign le = '0;
      assign lv = 1'b0;
    end else begin : g_l
      assign le = ent[i-1];
      assign lv = vld[i-1];
    end
    if (i == DEPTH - 1) begin : g_rl
      assign re = '0;
      assign rv = 1'b0;
    end else begin : g_r
      assign re = ent[i+1];
      assign rv = vld[i+1];
    end
    tcpq_cell #(.IS_HEAD(i == 0)) u_cell (
      .clk, .rst_n, .op,
      .stay_in(stay[i]), .hit_in(hit[i]),
      .left_entry(le), .left_valid(lv),
      .right_entry(re), .right_valid(rv),
      .entry(ent[i]), .valid(vld[i]),
      .stay_out(stay[i+1]), .hit_out(hit[i+1]), .first_hit(first[i])
    );
  end

  always_comb begin
    found_entry = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) found_entry = found_entry | ent[i];
    end
  end

  assign found      = hit[DEPTH];
  assign head_entry = ent[0];

endmodule

// ----- hw/rtl/two_class_priority_queue_undo_core.sv -----
// -----------------------------------------------------------------------------
// two_class_priority_queue_undo_core: priority + FIFO queue with undo history
// Top level: command sequencer, two cell rows and the history ring memory.
// -----------------------------------------------------------------------------
// One command is taken while busy is low and answered by a one-cycle out_valid
// pulse; the receiver cannot stall it. A command runs from idle through execute
// to the result state; a found boost adds an insert state, a popping undo adds
// a history read and an undo execute state (and an insert state to reverse a
// boost). The next item can be taken in the cycle after the result. Each row
// of cells searches combinationally and shifts or inserts; boost needs a remove
// then an insert, and undo adds a registered read of the history memory. Both
// entry rows are cleared at reset through their valid bits.
module two_class_priority_queue_undo_core #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int HISTORY_DEPTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  tcpq_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output tcpq_pkg::out_item_t  out_item
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int HW = $clog2(HISTORY_DEPTH + 1);
  localparam int TW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [CW-1:0] QFULL = CW'(QUEUE_DEPTH);
  localparam logic [HW-1:0] HFULL = HW'(HISTORY_DEPTH);
  localparam logic [TW-1:0] TLAST = TW'(HISTORY_DEPTH - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_BOOST   = 3'd2;
  localparam logic [2:0] S_UNDO_RD = 3'd3;
  localparam logic [2:0] S_UNDO_EX = 3'd4;
  localparam logic [2:0] S_UNDO_IN = 3'd5;
  localparam logic [2:0] S_RESP    = 3'd6;

  logic [2:0] state_r, state_nxt;
  tcpq_pkg::in_item_t cmd_r;
  logic [2:0]  status_r, status_nxt;
  tcpq_pkg::entry_t srv_r, srv_nxt;
  logic        srv_prio_r, srv_prio_nxt;
  tcpq_pkg::entry_t work_r, work_nxt;
  logic [CW-1:0] pq_cnt_r, pq_cnt_nxt, ff_cnt_r, ff_cnt_nxt;
  logic [15:0]   arr_r, arr_nxt;
  logic [HW-1:0] hused_r, hused_nxt;
  logic [TW-1:0] htop_r, htop_nxt;

  tcpq_pkg::hist_rec_t hist_mem [HISTORY_DEPTH];
  tcpq_pkg::hist_rec_t hist_rd_r, hist_wdata;
  logic                hist_we;

  tcpq_pkg::row_op_t pq_op, ff_op;
  logic              pq_found, ff_found;
  tcpq_pkg::entry_t  pq_fe, ff_fe, pq_head, ff_head;
  logic              pq_full, ff_full;

  tcpq_row #(.DEPTH(QUEUE_DEPTH)) u_pq (
    .clk, .rst_n, .op(pq_op), .found(pq_found), .found_entry(pq_fe), .head_entry(pq_head)
  );
  tcpq_row #(.DEPTH(QUEUE_DEPTH)) u_ff (
    .clk, .rst_n, .op(ff_op), .found(ff_found), .found_entry(ff_fe), .head_entry(ff_head)
  );

  assign pq_full = (pq_cnt_r == QFULL);
  assign ff_full = (ff_cnt_r == QFULL);

  always_comb begin
    state_nxt    = state_r;
    status_nxt   = status_r;
    srv_nxt      = srv_r;
    srv_prio_nxt = srv_prio_r;
    work_nxt     = work_r;
    pq_cnt_nxt   = pq_cnt_r;
    ff_cnt_nxt   = ff_cnt_r;
    arr_nxt      = arr_r;
    hused_nxt    = hused_r;
    htop_nxt     = htop_r;
    hist_we      = 1'b0;
    hist_wdata   = '0;
    pq_op        = '0;
    ff_op        = '0;
    ff_op.fifo_mode = 1'b1;
    pq_op.key    = (state_r == S_UNDO_EX) ? hist_rd_r.e.id : cmd_r.entry_id;
    ff_op.key    = pq_op.key;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          status_nxt   = tcpq_pkg::ST_DONE;
          srv_nxt      = '0;
          srv_prio_nxt = 1'b0;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        unique case (cmd_r.mode)
          tcpq_pkg::MODE_REGISTER: begin
            if (pq_found || ff_found) begin
              status_nxt = tcpq_pkg::ST_IGNORED;
            end else if (cmd_r.is_priority ? pq_full : ff_full) begin
              status_nxt = tcpq_pkg::ST_FULL;
            end else begin
              hist_wdata.e = '{id: cmd_r.entry_id, level: cmd_r.level, arrival: arr_r};
              hist_wdata.prio = cmd_r.is_priority;
              hist_wdata.code = tcpq_pkg::ACT_REGISTER;
              hist_we = 1'b1;
              if (cmd_r.is_priority) begin
                pq_op.do_ins = 1'b1;
                pq_op.ins_entry = hist_wdata.e;
                pq_cnt_nxt = pq_cnt_r + 1'b1;
              end else begin
                ff_op.do_ins = 1'b1;
                ff_op.ins_entry = hist_wdata.e;
                ff_cnt_nxt = ff_cnt_r + 1'b1;
              end
              if (arr_r != 16'hffff) arr_nxt = arr_r + 16'd1;
            end
          end
          tcpq_pkg::MODE_SERVE: begin
            if (pq_cnt_r != '0) begin
              pq_op.do_rem = 1'b1;
              pq_op.head_sel = 1'b1;
              pq_cnt_nxt = pq_cnt_r - 1'b1;
              srv_nxt = pq_head;
              srv_prio_nxt = 1'b1;
              hist_wdata.e = pq_head;
              hist_wdata.prio = 1'b1;
              hist_wdata.code = tcpq_pkg::ACT_SERVE;
              hist_we = 1'b1;
            end else if (ff_cnt_r != '0) begin
              ff_op.do_rem = 1'b1;
              ff_op.head_sel = 1'b1;
              ff_cnt_nxt = ff_cnt_r - 1'b1;
              srv_nxt = ff_head;
              hist_wdata.e = ff_head;
              hist_wdata.code = tcpq_pkg::ACT_SERVE;
              hist_we = 1'b1;
            end else begin
              status_nxt = tcpq_pkg::ST_EMPTY;
            end
          end
          tcpq_pkg::MODE_BOOST: begin
            if (!pq_found) begin
              status_nxt = tcpq_pkg::ST_IGNORED;
            end else begin
              work_nxt = pq_fe;
              work_nxt.level = tcpq_pkg::sat_add(pq_fe.level, cmd_r.boost_amount, 1'b0);
              pq_op.do_rem = 1'b1;
              pq_cnt_nxt = pq_cnt_r - 1'b1;
              state_nxt = S_BOOST;
            end
          end
          tcpq_pkg::MODE_WITHDRAW: begin
            hist_wdata.code = tcpq_pkg::ACT_WITHDRAW;
            if (ff_found) begin
              ff_op.do_rem = 1'b1;
              ff_cnt_nxt = ff_cnt_r - 1'b1;
              hist_wdata.e = ff_fe;
              hist_we = 1'b1;
            end else if (pq_found) begin
              pq_op.do_rem = 1'b1;
              pq_cnt_nxt = pq_cnt_r - 1'b1;
              hist_wdata.e = pq_fe;
              hist_wdata.prio = 1'b1;
              hist_we = 1'b1;
            end else begin
              status_nxt = tcpq_pkg::ST_IGNORED;
            end
          end
          tcpq_pkg::MODE_UNDO: begin
            if (hused_r == '0) begin
              status_nxt = tcpq_pkg::ST_HIST_EMPTY;
            end else begin
              htop_nxt  = (htop_r == '0) ? TLAST : htop_r - 1'b1;
              hused_nxt = hused_r - 1'b1;
              state_nxt = S_UNDO_RD;
            end
          end
          tcpq_pkg::MODE_STATUS: begin
            status_nxt = tcpq_pkg::ST_DONE;
          end
          default: begin
            status_nxt = tcpq_pkg::ST_IGNORED;
          end
        endcase
      end
      S_BOOST: begin
        pq_op.do_ins = 1'b1;
        pq_op.ins_entry = work_r;
        pq_cnt_nxt = pq_cnt_r + 1'b1;
        hist_wdata.e = work_r;
        hist_wdata.prio = 1'b1;
        hist_wdata.code = tcpq_pkg::ACT_BOOST;
        hist_wdata.amount = cmd_r.boost_amount;
        hist_we = 1'b1;
        state_nxt = S_RESP;
      end
      S_UNDO_RD: begin
        state_nxt = S_UNDO_EX;
      end
      S_UNDO_EX: begin
        work_nxt  = hist_rd_r.e;
        state_nxt = S_RESP;
        unique case (hist_rd_r.code)
          tcpq_pkg::ACT_REGISTER: begin
            if (hist_rd_r.prio) begin
              if (pq_found) begin
                pq_op.do_rem = 1'b1;
                pq_cnt_nxt = pq_cnt_r - 1'b1;
              end
            end else if (ff_found) begin
              ff_op.do_rem = 1'b1;
              ff_cnt_nxt = ff_cnt_r - 1'b1;
            end
          end
          tcpq_pkg::ACT_BOOST: begin
            if (pq_found) begin
              pq_op.do_rem = 1'b1;
              pq_cnt_nxt = pq_cnt_r - 1'b1;
            end
            work_nxt.level = tcpq_pkg::sat_add(hist_rd_r.e.level, hist_rd_r.amount, 1'b1);
            state_nxt = S_UNDO_IN;
          end
          default: begin
            if (hist_rd_r.prio) begin
              if (pq_full) begin
                status_nxt = tcpq_pkg::ST_FULL;
              end else begin
                pq_op.do_ins = 1'b1;
                pq_op.ins_entry = hist_rd_r.e;
                pq_cnt_nxt = pq_cnt_r + 1'b1;
              end
            end else if (ff_full) begin
              status_nxt = tcpq_pkg::ST_FULL;
            end else begin
              ff_op.do_ins = 1'b1;
              ff_op.ins_entry = hist_rd_r.e;
              ff_cnt_nxt = ff_cnt_r + 1'b1;
            end
          end
        endcase
      end
      S_UNDO_IN: begin
        if (pq_full) begin
          status_nxt = tcpq_pkg::ST_FULL;
        end else begin
          pq_op.do_ins = 1'b1;
          pq_op.ins_entry = work_r;
          pq_cnt_nxt = pq_cnt_r + 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (hist_we) begin
      htop_nxt = (htop_r == TLAST) ? '0 : htop_r + 1'b1;
      if (hused_r != HFULL) hused_nxt = hused_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pq_cnt_r <= '0;
      ff_cnt_r <= '0;
      arr_r    <= '0;
      hused_r  <= '0;
      htop_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      pq_cnt_r <= pq_cnt_nxt;
      ff_cnt_r <= ff_cnt_nxt;
      arr_r    <= arr_nxt;
      hused_r  <= hused_nxt;
      htop_r   <= htop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) cmd_r <= in_item;
    status_r   <= status_nxt;
    srv_r      <= srv_nxt;
    srv_prio_r <= srv_prio_nxt;
    work_r     <= work_nxt;
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[htop_r] <= hist_wdata;
    hist_rd_r <= hist_mem[htop_r];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);
  assign out_item  = '{status_code: status_r, served_id: srv_r.id,
                       served_level: srv_r.level, served_was_priority: srv_prio_r,
                       priority_count: 5'(pq_cnt_r), fifo_count: 5'(ff_cnt_r)};

endmodule

// ----- hw/rtl/tcpq_checker.sv -----
// -----------------------------------------------------------------------------
// tcpq_checker: port-level checks
// Command/result sequencing seen on the top-level ports.
// -----------------------------------------------------------------------------
module tcpq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input tcpq_pkg::out_item_t out_item
);

  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("item accepted but not busy");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a command");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("still busy after result");

  a_served_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status_code != tcpq_pkg::ST_DONE) |->
      (out_item.served_id == 16'd0 && !out_item.served_was_priority))
    else $error("served fields set on failed command");

endmodule

bind two_class_priority_queue_undo_core tcpq_checker u_tcpq_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
